// ===== rtl/core/cvmm_pkg.sv =====
// shared constants, item and result types for the complex matrix-vector multiplier
// no dependencies
package cvmm_pkg;

    localparam int MAX_QUBITS  = 10;
    localparam int VEC_DEPTH   = 1 << MAX_QUBITS;
    localparam int IDX_W       = MAX_QUBITS;
    localparam int CFG_W       = 4;
    localparam int SMP_W       = 16;
    localparam int PRD_W       = 2 * SMP_W;
    localparam int SUM_W       = PRD_W + 1;
    localparam int ACC_W       = 48;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_W-1:0] QUBITS_RESET = CFG_W'(10);

    typedef struct packed {
        logic                    is_load;
        logic                    first;
        logic                    emit;
        logic                    last;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [SMP_W-1:0] re;
        logic signed [SMP_W-1:0] im;
    } t_item;

    typedef struct packed {
        logic signed [ACC_W-1:0] sum_re;
        logic signed [ACC_W-1:0] sum_im;
        logic [IDX_W-1:0]        index;
        logic                    last;
    } t_result;

endpackage

// ===== rtl/core/cvmm_front.sv =====
// front end: qubit count register, frame sequencing, classification of requests
// depends on cvmm_pkg
module cvmm_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_full,
    input  logic signed [cvmm_pkg::SMP_W-1:0] i_sample_re,
    input  logic signed [cvmm_pkg::SMP_W-1:0] i_sample_im,
    input  logic                        i_cfg_wr,
    input  logic [cvmm_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                        o_push,
    output cvmm_pkg::t_item             o_item
);

    logic [cvmm_pkg::CFG_W-1:0] r_qubits;
    logic                       r_loading;
    logic [cvmm_pkg::IDX_W-1:0] r_row;
    logic [cvmm_pkg::IDX_W-1:0] r_col;

    logic [cvmm_pkg::CFG_W-1:0] q_eff;
    logic [cvmm_pkg::IDX_W:0]   len;
    logic [cvmm_pkg::IDX_W-1:0] lim;
    logic                       accept;
    logic                       col_end;
    logic                       row_end;

    always_comb begin
        if (r_qubits == '0) begin
            q_eff = cvmm_pkg::CFG_W'(1);
        end else if (r_qubits > cvmm_pkg::CFG_W'(cvmm_pkg::MAX_QUBITS)) begin
            q_eff = cvmm_pkg::CFG_W'(cvmm_pkg::MAX_QUBITS);
        end else begin
            q_eff = r_qubits;
        end
        len = (cvmm_pkg::IDX_W + 1)'(1) << q_eff;
        lim = cvmm_pkg::IDX_W'(len - (cvmm_pkg::IDX_W + 1)'(1));
    end

    assign accept  = i_start && !i_full;
    assign col_end = (r_col == lim);
    assign row_end = (r_row == lim);

    assign o_push         = accept;
    assign o_item.is_load = r_loading;
    assign o_item.first   = (r_row == '0);
    assign o_item.emit    = row_end;
    assign o_item.last    = col_end;
    assign o_item.row     = r_row;
    assign o_item.col     = r_col;
    assign o_item.re      = i_sample_re;
    assign o_item.im      = i_sample_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qubits  <= cvmm_pkg::QUBITS_RESET;
            r_loading <= 1'b1;
            r_row     <= '0;
            r_col     <= '0;
        end else if (i_cfg_wr) begin
            r_qubits  <= i_cfg_data;
            r_loading <= 1'b1;
            r_row     <= '0;
            r_col     <= '0;
        end else if (accept) begin
            if (col_end) begin
                r_col <= '0;
                if (r_loading) begin
                    r_loading <= 1'b0;
                    r_row     <= '0;
                end else if (row_end) begin
                    r_loading <= 1'b1;
                    r_row     <= '0;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/cvmm_queue.sv =====
// short request queue between front end and back end
// depends on cvmm_pkg
module cvmm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cvmm_pkg::t_item i_item,
    input  logic            i_pop,
    output cvmm_pkg::t_item o_item,
    output logic            o_full,
    output logic            o_empty
);

    cvmm_pkg::t_item               r_slot [cvmm_pkg::QUEUE_DEPTH];
    logic [cvmm_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [cvmm_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [cvmm_pkg::QPTR_W:0]     r_count;

    assign o_item  = r_slot[r_rd_ptr];
    assign o_full  = (r_count == (cvmm_pkg::QPTR_W + 1)'(cvmm_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/core/cvmm_back.sv =====
// back end: amplitude and accumulator memories, complex multiply-accumulate
// depends on cvmm_pkg
module cvmm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  cvmm_pkg::t_item   i_item,
    output logic              o_pop,
    output logic              o_idle,
    output logic              o_done,
    output cvmm_pkg::t_result o_result
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_SUM  = 4'b0100,
        S_ACC  = 4'b1000
    } t_state;

    localparam logic signed [cvmm_pkg::ACC_W-1:0] ACC_MAX =
        {1'b0, {(cvmm_pkg::ACC_W - 1){1'b1}}};
    localparam logic signed [cvmm_pkg::ACC_W-1:0] ACC_MIN =
        {1'b1, {(cvmm_pkg::ACC_W - 1){1'b0}}};

    t_state r_state;
    t_state n_state;
    logic   r_done;

    logic [2*cvmm_pkg::SMP_W-1:0] r_vec [cvmm_pkg::VEC_DEPTH];
    logic [2*cvmm_pkg::ACC_W-1:0] r_acc_mem [cvmm_pkg::VEC_DEPTH];

    cvmm_pkg::t_item               r_item;
    logic signed [cvmm_pkg::SMP_W-1:0] r_amp_re;
    logic signed [cvmm_pkg::SMP_W-1:0] r_amp_im;
    logic signed [cvmm_pkg::ACC_W-1:0] r_acc_re;
    logic signed [cvmm_pkg::ACC_W-1:0] r_acc_im;
    logic signed [cvmm_pkg::PRD_W-1:0] r_p_rr;
    logic signed [cvmm_pkg::PRD_W-1:0] r_p_ii;
    logic signed [cvmm_pkg::PRD_W-1:0] r_p_ri;
    logic signed [cvmm_pkg::PRD_W-1:0] r_p_ir;
    logic signed [cvmm_pkg::SUM_W-1:0] r_pr;
    logic signed [cvmm_pkg::SUM_W-1:0] r_pi;
    cvmm_pkg::t_result                 r_result;

    logic signed [cvmm_pkg::ACC_W-1:0] sat_re;
    logic signed [cvmm_pkg::ACC_W-1:0] sat_im;

    function automatic logic signed [cvmm_pkg::ACC_W-1:0] sat_add(
        input logic signed [cvmm_pkg::ACC_W-1:0] acc,
        input logic signed [cvmm_pkg::SUM_W-1:0] inc
    );
        logic signed [cvmm_pkg::ACC_W:0] s;
        s = (cvmm_pkg::ACC_W + 1)'(acc) + (cvmm_pkg::ACC_W + 1)'(inc);
        if (s[cvmm_pkg::ACC_W] != s[cvmm_pkg::ACC_W-1]) begin
            return s[cvmm_pkg::ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[cvmm_pkg::ACC_W-1:0];
    endfunction

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_idle   = (r_state == S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // first row starts from zero, so no clearing pass is needed
    always_comb begin
        sat_re = sat_add(r_item.first ? '0 : r_acc_re, r_pr);
        sat_im = sat_add(r_item.first ? '0 : r_acc_im, r_pi);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty && !i_item.is_load) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_ACC;
            S_ACC:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_ACC) && r_item.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
            if (i_item.is_load) begin
                r_vec[i_item.col] <= {i_item.re, i_item.im};
            end else begin
                {r_amp_re, r_amp_im} <= r_vec[i_item.row];
                {r_acc_re, r_acc_im} <= r_acc_mem[i_item.col];
            end
        end
        if (r_state == S_MUL) begin
            r_p_rr <= r_amp_re * r_item.re;
            r_p_ii <= r_amp_im * r_item.im;
            r_p_ri <= r_amp_re * r_item.im;
            r_p_ir <= r_amp_im * r_item.re;
        end
        if (r_state == S_SUM) begin
            r_pr <= cvmm_pkg::SUM_W'(r_p_rr) - cvmm_pkg::SUM_W'(r_p_ii);
            r_pi <= cvmm_pkg::SUM_W'(r_p_ri) + cvmm_pkg::SUM_W'(r_p_ir);
        end
        if (r_state == S_ACC) begin
            r_acc_mem[r_item.col] <= {sat_re, sat_im};
            if (r_item.emit) begin
                r_result.sum_re <= sat_re;
                r_result.sum_im <= sat_im;
                r_result.index  <= r_item.col;
                r_result.last   <= r_item.last;
            end
        end
    end

endmodule

// ===== rtl/core/complex_vector_matrix_multiply.sv =====
// a result goes through queue slot, item register, S_MUL, S_SUM, S_ACC, strobe register
// back end: one vector sample per cycle when idle; next matrix element only after S_ACC
// requests are taken at one per cycle until the 4-entry queue fills (busy high)
// the receiver cannot stall: each result is shown for one cycle with o_strobe
// synchronous active-low reset: loading phase, qubit count 10, queue empty; no clearing pass
// top level: front end, request queue, back end; depends on cvmm_pkg and the three submodules
module complex_vector_matrix_multiply (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [cvmm_pkg::SMP_W-1:0] i_sample_re,
    input  logic signed [cvmm_pkg::SMP_W-1:0] i_sample_im,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cvmm_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                              o_strobe,
    output logic signed [cvmm_pkg::ACC_W-1:0] o_sum_re,
    output logic signed [cvmm_pkg::ACC_W-1:0] o_sum_im,
    output logic [cvmm_pkg::IDX_W-1:0]        o_entry_index,
    output logic                              o_last
);

    cvmm_pkg::t_item   push_item;
    cvmm_pkg::t_item   head_item;
    cvmm_pkg::t_result result;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    logic              back_idle;
    logic              cfg_wr;

    assign busy        = full;
    assign o_cfg_ready = empty && back_idle;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    cvmm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_full      (full),
        .i_sample_re (i_sample_re),
        .i_sample_im (i_sample_im),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_item      (push_item)
    );

    cvmm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_full  (full),
        .o_empty (empty)
    );

    cvmm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_item   (head_item),
        .o_pop    (pop),
        .o_idle   (back_idle),
        .o_done   (o_strobe),
        .o_result (result)
    );

    assign o_sum_re      = result.sum_re;
    assign o_sum_im      = result.sum_im;
    assign o_entry_index = result.index;
    assign o_last        = result.last;

endmodule

// ===== rtl/core/cvmm_checker.sv =====
// port-level checks for the complex matrix-vector multiplier, bound to the top level
// depends on cvmm_pkg and complex_vector_matrix_multiply
module cvmm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       busy,
    input logic                       o_cfg_ready,
    input logic                       o_strobe,
    input logic [cvmm_pkg::IDX_W-1:0] o_entry_index,
    input logic                       o_last
);

    // back end returns to S_IDLE between matrix elements, so result strobes never come back to back
    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobes in consecutive cycles");

    // vector length is at least two, so the last column is never column zero
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> (o_entry_index != '0))
        else $error("last flag on column zero");

    a_cfg_vs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cfg_ready && busy))
        else $error("config ready while request queue full");

    a_reset_quiet: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (!busy && !o_strobe && o_cfg_ready))
        else $error("not idle after reset");

endmodule

bind complex_vector_matrix_multiply cvmm_checker u_cvmm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .busy          (busy),
    .o_cfg_ready   (o_cfg_ready),
    .o_strobe      (o_strobe),
    .o_entry_index (o_entry_index),
    .o_last        (o_last)
);

// ===== dv/complex_vector_matrix_multiply_tb.sv =====
// self-checking testbench for complex_vector_matrix_multiply: vector load, matrix stream, column sums
// depends on cvmm_pkg and the complex_vector_matrix_multiply rtl
module complex_vector_matrix_multiply_tb;

    localparam int          ITEM_TARGET   = 950;
    localparam int          IDLE_PCT      = 38;
    localparam int          PAUSE_AT      = 650;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam longint      SUM_MAX       = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint      SUM_MIN       = -SUM_MAX - 1;
    localparam logic [15:0] SMP_MIN       = 16'h8000;
    localparam logic [15:0] SMP_MAX       = 16'h7FFF;

    typedef enum logic {STEP_SAMPLE, STEP_QUBITS} t_step_kind;

    typedef struct {
        t_step_kind                           kind;
        logic signed [cvmm_pkg::SMP_W-1:0]    re;
        logic signed [cvmm_pkg::SMP_W-1:0]    im;
        logic [cvmm_pkg::CFG_W-1:0]           qubits;
        bit                                   typed;
        cvmm_pkg::t_result                    want;
    } t_step;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic signed [cvmm_pkg::SMP_W-1:0] i_sample_re;
    logic signed [cvmm_pkg::SMP_W-1:0] i_sample_im;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [cvmm_pkg::CFG_W-1:0]        i_cfg_data;
    logic                              o_strobe;
    logic signed [cvmm_pkg::ACC_W-1:0] o_sum_re;
    logic signed [cvmm_pkg::ACC_W-1:0] o_sum_im;
    logic [cvmm_pkg::IDX_W-1:0]        o_entry_index;
    logic                              o_last;

    logic [cvmm_pkg::CFG_W-1:0]        qubits_reg;
    logic signed [cvmm_pkg::SMP_W-1:0] amp_re [cvmm_pkg::VEC_DEPTH];
    logic signed [cvmm_pkg::SMP_W-1:0] amp_im [cvmm_pkg::VEC_DEPTH];
    longint                            col_sum_re [cvmm_pkg::VEC_DEPTH];
    longint                            col_sum_im [cvmm_pkg::VEC_DEPTH];
    bit                                loading;
    int unsigned                       row_idx;
    int unsigned                       col_idx;

    cvmm_pkg::t_result                 pending_sums [$];
    t_step                             directed [$];
    int                                items_sent = 0;
    int                                mismatches = 0;
    int                                cycle_count = 0;

    complex_vector_matrix_multiply DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_sample_re   (i_sample_re),
        .i_sample_im   (i_sample_im),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_sum_re      (o_sum_re),
        .o_sum_im      (o_sum_im),
        .o_entry_index (o_entry_index),
        .o_last        (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned vector_len();
        int unsigned q;
        q = qubits_reg;
        if (q < 1) q = 1;
        if (q > cvmm_pkg::MAX_QUBITS) q = cvmm_pkg::MAX_QUBITS;
        return 1 << q;
    endfunction

    function automatic longint sat48(input longint v);
        if (v > SUM_MAX) return SUM_MAX;
        if (v < SUM_MIN) return SUM_MIN;
        return v;
    endfunction

    function automatic void restart_frame();
        for (int i = 0; i < cvmm_pkg::VEC_DEPTH; i++) begin
            col_sum_re[i] = 0;
            col_sum_im[i] = 0;
        end
        loading = 1'b1;
        row_idx = 0;
        col_idx = 0;
    endfunction

    function automatic bit column_mac(input logic signed [cvmm_pkg::SMP_W-1:0] er,
                                      input logic signed [cvmm_pkg::SMP_W-1:0] ei,
                                      output cvmm_pkg::t_result res);
        int unsigned lim;
        int unsigned r;
        int unsigned c;
        longint      ar;
        longint      ai;
        longint      pr;
        longint      pi;
        bit          hit;
        lim = vector_len() - 1;
        r   = row_idx;
        c   = col_idx;
        res = '0;
        hit = 1'b0;
        if (loading) begin
            amp_re[c] = er;
            amp_im[c] = ei;
            if (c >= lim) begin
                loading = 1'b0;
                row_idx = 0;
                col_idx = 0;
            end else begin
                col_idx = c + 1;
            end
            return 1'b0;
        end
        ar = amp_re[r];
        ai = amp_im[r];
        pr = ar * longint'(er) - ai * longint'(ei);
        pi = ar * longint'(ei) + ai * longint'(er);
        col_sum_re[c] = sat48(col_sum_re[c] + pr);
        col_sum_im[c] = sat48(col_sum_im[c] + pi);
        if (r >= lim) begin
            res.sum_re    = cvmm_pkg::ACC_W'(col_sum_re[c]);
            res.sum_im    = cvmm_pkg::ACC_W'(col_sum_im[c]);
            res.index     = cvmm_pkg::IDX_W'(c);
            res.last      = (c >= lim);
            col_sum_re[c] = 0;
            col_sum_im[c] = 0;
            hit           = 1'b1;
        end
        if (c >= lim) begin
            col_idx = 0;
            if (r >= lim) begin
                row_idx = 0;
                loading = 1'b1;
            end else begin
                row_idx = r + 1;
            end
        end else begin
            col_idx = c + 1;
        end
        return hit;
    endfunction

    function automatic logic signed [cvmm_pkg::SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return SMP_MIN;
            1: return SMP_MAX;
            default: return cvmm_pkg::SMP_W'($urandom);
        endcase
    endfunction

    function automatic t_step sample_row(input logic [15:0] re, input logic [15:0] im);
        t_step s;
        s = '{STEP_SAMPLE, re, im, '0, 1'b0, '0};
        return s;
    endfunction

    function automatic t_step qubits_row(input logic [cvmm_pkg::CFG_W-1:0] q);
        t_step s;
        s = '{STEP_QUBITS, '0, '0, q, 1'b0, '0};
        return s;
    endfunction

    function automatic t_step sum_row(input logic [15:0] re, input logic [15:0] im,
                                      input longint sre, input longint sim,
                                      input int idx, input bit lst);
        t_step s;
        s = '{STEP_SAMPLE, re, im, '0, 1'b1, '0};
        s.want.sum_re = cvmm_pkg::ACC_W'(sre);
        s.want.sum_im = cvmm_pkg::ACC_W'(sim);
        s.want.index  = cvmm_pkg::IDX_W'(idx);
        s.want.last   = lst;
        return s;
    endfunction

    task automatic send_sample(input logic signed [cvmm_pkg::SMP_W-1:0] re,
                               input logic signed [cvmm_pkg::SMP_W-1:0] im,
                               input bit typed, input cvmm_pkg::t_result want);
        int                idle;
        cvmm_pkg::t_result got;
        idle = (items_sent >= 300 && items_sent < 500) ? 0 : IDLE_PCT;
        if (items_sent == PAUSE_AT) begin
            start <= 1'b0;
            do @(posedge i_clk); while (pending_sums.size() != 0);
        end
        while ($urandom_range(0, 99) < idle) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_sample_re <= re;
        i_sample_im <= im;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (column_mac(re, im, got)) pending_sums.push_back(typed ? want : got);
    endtask

    task automatic write_qubits(input logic [cvmm_pkg::CFG_W-1:0] q);
        start <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= q;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        qubits_reg = q;
        restart_frame();
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        cvmm_pkg::t_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_sums.size() == 0) begin
                $error("unexpected result at entry_index %0d", o_entry_index);
                mismatches++;
            end else begin
                want = pending_sums.pop_front();
                if (o_sum_re !== want.sum_re) begin
                    $error("sum_re: expected %0d, got %0d", want.sum_re, o_sum_re);
                    mismatches++;
                end
                if (o_sum_im !== want.sum_im) begin
                    $error("sum_im: expected %0d, got %0d", want.sum_im, o_sum_im);
                    mismatches++;
                end
                if (o_entry_index !== want.index) begin
                    $error("entry_index: expected %0d, got %0d", want.index, o_entry_index);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int unsigned n;
        int          pick;
        int          frames;
        int          count;
        logic [cvmm_pkg::CFG_W-1:0] q;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_sample_re <= '0;
        i_sample_im <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        qubits_reg = cvmm_pkg::QUBITS_RESET;
        for (int i = 0; i < cvmm_pkg::VEC_DEPTH; i++) begin
            amp_re[i] = '0;
            amp_im[i] = '0;
        end
        restart_frame();

        // reset state: full-length vector, partial load only
        directed.push_back(sample_row(SMP_MIN, SMP_MAX));
        directed.push_back(sample_row(SMP_MAX, SMP_MIN));
        directed.push_back(sample_row(16'h0000, 16'hFFFF));
        // zero qubits acts as one: two-entry vector
        directed.push_back(qubits_row(4'd0));
        directed.push_back(sample_row(SMP_MIN, 16'h0000));
        directed.push_back(sample_row(16'h0000, 16'h0000));
        directed.push_back(sample_row(SMP_MIN, 16'h0000));
        directed.push_back(sample_row(SMP_MAX, SMP_MIN));
        directed.push_back(sum_row(SMP_MAX, SMP_MAX, 64'sd1073741824, 0, 0, 1'b0));
        directed.push_back(sum_row(SMP_MIN, SMP_MIN,
                                   -64'sd1073709056, 64'sd1073741824, 1, 1'b1));
        // frame cut off mid-matrix, accumulators must be cleared
        directed.push_back(qubits_row(4'd1));
        directed.push_back(sample_row(SMP_MAX, SMP_MAX));
        directed.push_back(sample_row(SMP_MIN, SMP_MIN));
        directed.push_back(sample_row(SMP_MAX, SMP_MIN));
        // oversized qubit count clamps to the maximum
        directed.push_back(qubits_row(4'd15));
        directed.push_back(sample_row(16'h5555, 16'hAAAA));
        directed.push_back(sample_row(16'hAAAA, 16'h5555));
        directed.push_back(sample_row(16'h0001, 16'hFFFF));
        directed.push_back(sample_row(16'hFFFF, 16'h0001));
        directed.push_back(qubits_row(4'd1));
        directed.push_back(sample_row(SMP_MAX, SMP_MIN));
        directed.push_back(sample_row(SMP_MIN, SMP_MAX));
        directed.push_back(sample_row(SMP_MAX, SMP_MAX));
        directed.push_back(sample_row(SMP_MIN, SMP_MIN));
        directed.push_back(sample_row(16'hFFFF, 16'h0001));
        directed.push_back(sample_row(16'h0000, 16'hFFFF));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].kind == STEP_QUBITS) begin
                write_qubits(directed[i].qubits);
            end else begin
                send_sample(directed[i].re, directed[i].im, directed[i].typed,
                            directed[i].want);
            end
        end

        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) q = 4'd0;
            else if (pick < 38) q = 4'd1;
            else if (pick < 68) q = 4'd2;
            else if (pick < 88) q = 4'd3;
            else if (pick < 95) q = 4'd4;
            else q = 4'($urandom_range(10, 15));
            write_qubits(q);
            if (q > 4) begin
                count = $urandom_range(1, 40);
                for (int i = 0; i < count && items_sent < ITEM_TARGET; i++)
                    send_sample(rand_sample(), rand_sample(), 0, '0);
            end else begin
                n      = vector_len();
                frames = (q == 4) ? 1 : $urandom_range(1, 3);
                for (int f = 0; f < frames && items_sent < ITEM_TARGET; f++) begin
                    count = n + n * n;
                    if (f == frames - 1 && $urandom_range(0, 99) < 15)
                        count = $urandom_range(1, count - 1);
                    for (int i = 0; i < count && items_sent < ITEM_TARGET; i++)
                        send_sample(rand_sample(), rand_sample(), 0, '0);
                end
            end
        end

        start <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
